[hdl/ddm_pkg.sv]
// ----------------------------------------------------------------------------
// ddm_pkg
// Shared constants, widths and controller-to-datapath command type for the
// differential drive mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package ddm_pkg;

    // Fixed-point scale of every drive quantity
    localparam int FRAC_BITS = 14;
    localparam longint ONE = longint'(1) << FRAC_BITS;
    localparam longint K02 = (ONE * 2 + 5) / 10;
    localparam longint K09 = (ONE * 9 + 5) / 10;

    // Field widths
    localparam int IN_W   = 16;
    localparam int OUT_W  = 19;
    localparam int ACC_W  = 17;
    localparam int DB_W   = 15;
    localparam int GAIN_W = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_THR_DB = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_WHL_DB = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = CFG_IDX_W'(2);

    localparam logic [DB_W-1:0]   THR_DB_RST = DB_W'(328);
    localparam logic [DB_W-1:0]   WHL_DB_RST = DB_W'(328);
    localparam logic [GAIN_W-1:0] GAIN_RST   = GAIN_W'(ONE);

    // Shared multiplier and internal arithmetic widths
    localparam int MUL_A_W = IN_W + 2;
    localparam int MUL_B_W = IN_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int SHR_W   = PROD_W - FRAC_BITS;
    localparam int SUM_W   = SHR_W + 3;

    typedef struct packed {
        logic load_in;     // capture a transferred input item
        logic mul_first;   // first product of the item
        logic mul_second;  // second product of the item
        logic finish;      // form the result, update the accumulator
    } t_dp_cmd;

endpackage

`default_nettype wire

[hdl/ddm_in_if.sv]
// ----------------------------------------------------------------------------
// ddm_in_if
// Input command channel: throttle, wheel and quick-turn flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface ddm_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [ddm_pkg::IN_W-1:0]       throttle_in;
    logic signed [ddm_pkg::IN_W-1:0]       wheel_in;
    logic                                  quick_turn;

    modport source (output valid, output throttle_in, output wheel_in,
                    output quick_turn, input ready);
    modport sink   (input valid, input throttle_in, input wheel_in,
                    input quick_turn, output ready);
endinterface

`default_nettype wire

[hdl/ddm_out_if.sv]
// ----------------------------------------------------------------------------
// ddm_out_if
// Result channel: left and right side drive values.
// ----------------------------------------------------------------------------
`default_nettype none

interface ddm_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [ddm_pkg::OUT_W-1:0]      left_drive;
    logic signed [ddm_pkg::OUT_W-1:0]      right_drive;

    modport source (output valid, output left_drive, output right_drive,
                    input ready);
    modport sink   (input valid, input left_drive, input right_drive,
                    output ready);
endinterface

`default_nettype wire

[hdl/ddm_cfg_if.sv]
// ----------------------------------------------------------------------------
// ddm_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface ddm_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [ddm_pkg::CFG_IDX_W-1:0]         index;
    logic [ddm_pkg::CFG_DATA_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/ddm_ctrl.sv]
// ----------------------------------------------------------------------------
// ddm_ctrl
// Sequencer for the mixer: accepts an item, steps the shared multiplier
// twice, then finishes into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ddm_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire             i_out_ready,
    output ddm_pkg::t_dp_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL1 = 2'd1;
    localparam logic [1:0] S_MUL2 = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid;
        o_cmd         = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.mul_first = 1'b1;
                n_state         = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_second = 1'b1;
                n_state          = S_FIN;
            end
            S_FIN: begin
                // hold until the output register can take the result
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

[hdl/ddm_datapath.sv]
// ----------------------------------------------------------------------------
// ddm_datapath
// Configuration registers, input deadband, shared multiplier, quick-stop
// accumulator, side clamping and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ddm_datapath (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire ddm_pkg::t_dp_cmd                  i_cmd,
    input  wire signed [ddm_pkg::IN_W-1:0]         i_throttle,
    input  wire signed [ddm_pkg::IN_W-1:0]         i_wheel,
    input  wire                                    i_quick,
    input  wire                                    i_cfg_we,
    input  wire [ddm_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  wire [ddm_pkg::CFG_DATA_W-1:0]          i_cfg_data,
    output logic signed [ddm_pkg::OUT_W-1:0]       o_left_drive,
    output logic signed [ddm_pkg::OUT_W-1:0]       o_right_drive
);

    localparam int IN_W    = ddm_pkg::IN_W;
    localparam int ACC_W   = ddm_pkg::ACC_W;
    localparam int DB_W    = ddm_pkg::DB_W;
    localparam int GAIN_W  = ddm_pkg::GAIN_W;
    localparam int OUT_W   = ddm_pkg::OUT_W;
    localparam int MUL_A_W = ddm_pkg::MUL_A_W;
    localparam int MUL_B_W = ddm_pkg::MUL_B_W;
    localparam int PROD_W  = ddm_pkg::PROD_W;
    localparam int SHR_W   = ddm_pkg::SHR_W;
    localparam int SUM_W   = ddm_pkg::SUM_W;

    localparam logic signed [IN_W:0]      ONE_IN   = (IN_W+1)'(ddm_pkg::ONE);
    localparam logic [IN_W:0]             K02_MAG  = (IN_W+1)'(ddm_pkg::K02);
    localparam logic signed [MUL_B_W-1:0] K02_B    = MUL_B_W'(ddm_pkg::K02);
    localparam logic signed [MUL_B_W-1:0] K09_B    = MUL_B_W'(ddm_pkg::K09);
    localparam logic signed [SUM_W-1:0]   ONE_S    = SUM_W'(ddm_pkg::ONE);
    localparam logic signed [SUM_W-1:0]   OUT_MAX  = SUM_W'(8 * ddm_pkg::ONE);
    localparam logic signed [SUM_W-1:0]   ACC_MAX  = SUM_W'((longint'(1) << (ACC_W-1)) - 1);
    localparam logic signed [SUM_W-1:0]   ACC_MIN  = -SUM_W'(longint'(1) << (ACC_W-1));

    // Configuration registers
    logic [DB_W-1:0]   r_thr_db;
    logic [DB_W-1:0]   r_whl_db;
    logic [GAIN_W-1:0] r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_db <= ddm_pkg::THR_DB_RST;
            r_whl_db <= ddm_pkg::WHL_DB_RST;
            r_gain   <= ddm_pkg::GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ddm_pkg::CFG_THR_DB: r_thr_db <= i_cfg_data[DB_W-1:0];
                ddm_pkg::CFG_WHL_DB: r_whl_db <= i_cfg_data[DB_W-1:0];
                ddm_pkg::CFG_GAIN:   r_gain   <= i_cfg_data[GAIN_W-1:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // Deadband at capture
    logic signed [IN_W:0] in_thr_x, in_whl_x;
    logic [IN_W:0]        in_thr_mag, in_whl_mag;

    assign in_thr_x   = (IN_W+1)'(i_throttle);
    assign in_whl_x   = (IN_W+1)'(i_wheel);
    assign in_thr_mag = in_thr_x[IN_W] ? -in_thr_x : in_thr_x;
    assign in_whl_mag = in_whl_x[IN_W] ? -in_whl_x : in_whl_x;

    logic signed [IN_W-1:0]  r_thr, r_whl;
    logic                    r_quick;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_thr   <= (in_thr_mag > (IN_W+1)'(r_thr_db)) ? i_throttle : '0;
            r_whl   <= (in_whl_mag > (IN_W+1)'(r_whl_db)) ? i_wheel : '0;
            r_quick <= i_quick;
        end
    end

    // Shared multiplier
    logic signed [IN_W:0]        thr_x, whl_x, whl_clamp;
    logic [IN_W:0]               thr_abs;
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [SHR_W-1:0]     r_t1;
    logic signed [SHR_W-1:0]     prod_shr;
    logic signed [ACC_W-1:0]     r_acc;
    logic signed [MUL_A_W-1:0]   op_a;
    logic signed [MUL_B_W-1:0]   op_b;
    logic signed [PROD_W-1:0]    prod;

    assign thr_x     = (IN_W+1)'(r_thr);
    assign whl_x     = (IN_W+1)'(r_whl);
    assign thr_abs   = thr_x[IN_W] ? -thr_x : thr_x;
    assign whl_clamp = (whl_x > ONE_IN) ? ONE_IN : ((whl_x < -ONE_IN) ? -ONE_IN : whl_x);
    assign prod_shr  = SHR_W'(r_prod >>> ddm_pkg::FRAC_BITS);

    always_comb begin
        if (i_cmd.mul_second) begin
            if (r_quick) begin
                op_a = MUL_A_W'(whl_clamp);
                op_b = K02_B;
            end else begin
                op_a = MUL_A_W'(prod_shr);
                op_b = $signed(MUL_B_W'(r_gain));
            end
        end else begin
            if (r_quick) begin
                op_a = MUL_A_W'(r_acc);
                op_b = K09_B;
            end else begin
                op_a = $signed(MUL_A_W'(thr_abs));
                op_b = MUL_B_W'(r_whl);
            end
        end
    end

    assign prod = op_a * op_b;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_first) begin
            r_prod <= prod;
        end
        if (i_cmd.mul_second) begin
            r_t1   <= prod_shr;
            r_prod <= prod;
        end
    end

    // Turn, accumulator update and side limiting
    logic signed [SUM_W-1:0] thr_s, whl_s, acc_s, t1_s, t2_s;
    logic signed [SUM_W-1:0] acc_sum, acc_q, acc_decay, acc_nx;
    logic signed [SUM_W-1:0] ang, left0, right0, left1, right1, left_sat, right_sat;

    assign thr_s = SUM_W'(r_thr);
    assign whl_s = SUM_W'(r_whl);
    assign acc_s = SUM_W'(r_acc);
    assign t1_s  = SUM_W'(r_t1);
    assign t2_s  = SUM_W'(prod_shr);

    assign acc_sum   = t1_s + t2_s;
    assign acc_q     = (acc_sum > ACC_MAX) ? ACC_MAX :
                       ((acc_sum < ACC_MIN) ? ACC_MIN : acc_sum);
    assign acc_decay = (acc_s > ONE_S) ? (acc_s - ONE_S) :
                       ((acc_s < -ONE_S) ? (acc_s + ONE_S) : '0);

    always_comb begin
        if (r_quick) begin
            acc_nx = (thr_abs < K02_MAG) ? acc_q : acc_s;
            ang    = whl_s;
        end else begin
            acc_nx = acc_decay;
            ang    = t2_s - acc_s;
        end
        left0  = thr_s + ang;
        right0 = thr_s - ang;
        left1  = left0;
        right1 = right0;
        // clamp the first side past full scale; quick-turn moves the excess across
        if (left0 > ONE_S) begin
            left1 = ONE_S;
            if (r_quick) right1 = right0 - (left0 - ONE_S);
        end else if (right0 > ONE_S) begin
            right1 = ONE_S;
            if (r_quick) left1 = left0 - (right0 - ONE_S);
        end else if (left0 < -ONE_S) begin
            left1 = -ONE_S;
            if (r_quick) right1 = right0 + (-ONE_S - left0);
        end else if (right0 < -ONE_S) begin
            right1 = -ONE_S;
            if (r_quick) left1 = left0 + (-ONE_S - right0);
        end
        left_sat  = (left1 > OUT_MAX) ? OUT_MAX :
                    ((left1 < -OUT_MAX) ? -OUT_MAX : left1);
        right_sat = (right1 > OUT_MAX) ? OUT_MAX :
                    ((right1 < -OUT_MAX) ? -OUT_MAX : right1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_cmd.finish) begin
            r_acc <= ACC_W'(acc_nx);
        end
    end

    logic signed [OUT_W-1:0] r_left, r_right;

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_left  <= OUT_W'(left_sat);
            r_right <= OUT_W'(right_sat);
        end
    end

    assign o_left_drive  = r_left;
    assign o_right_drive = r_right;

endmodule

`default_nettype wire

[hdl/differential_drive_mixer.sv]
// ----------------------------------------------------------------------------
// differential_drive_mixer
// Curvature drive with quick-turn for a two-sided drive train.
//
// Channels: i_in takes throttle, wheel (signed Q1.14) and the quick-turn
// flag; o_out returns left and right drive (signed Q4.14, saturated at
// +-8.0); i_cfg writes throttle deadband (index 0), wheel deadband
// (index 1) and turn gain (index 2), and is always ready.
// After the input transfer the item makes two passes through the one
// shared 18x17 multiplier, then the finish step writes the output register.
// The controller steps idle, first product, second product and finish, and
// takes a new item only in idle, so one item is worked on at a time.
// If the receiver stalls, the result holds in the output register; the
// next item is still taken and waits in its finish step until the output
// register frees. Reset loads the register defaults (deadbands 328, gain
// 1.0), clears the quick-stop accumulator and empties the output.
// ----------------------------------------------------------------------------
`default_nettype none

module differential_drive_mixer (
    input  wire        i_clk,
    input  wire        i_rst_n,
    ddm_in_if.sink     i_in,
    ddm_out_if.source  o_out,
    ddm_cfg_if.sink    i_cfg
);

    ddm_pkg::t_dp_cmd cmd;
    logic             in_ready;
    logic             out_valid;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

    ddm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    ddm_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_throttle    (i_in.throttle_in),
        .i_wheel       (i_in.wheel_in),
        .i_quick       (i_in.quick_turn),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .o_left_drive  (o_out.left_drive),
        .o_right_drive (o_out.right_drive)
    );

endmodule

`default_nettype wire
